@@ design/gdrh_pkg.sv @@
// Shared types and constants for the graph degree rank histogram block.
// Holds the item and result payload structs, the controller/datapath
// command and status structs, and the function and status codes.
`default_nettype none

package gdrh_pkg;

	// Storage geometry and word widths
	localparam int MAX_VERTICES = 1024;
	localparam int VIDX_W       = 10;
	localparam int WORD_W       = 11;
	localparam int FUNC_W       = 2;
	localparam int STAT_W       = 2;

	localparam logic [WORD_W-1:0] WORD_MAX   = {WORD_W{1'b1}};
	localparam logic [WORD_W-1:0] VCNT_MIN   = WORD_W'(2);
	localparam logic [WORD_W-1:0] VCNT_MAX   = WORD_W'(MAX_VERTICES);
	localparam logic [WORD_W-1:0] VCNT_RESET = WORD_W'(MAX_VERTICES);

	// Function codes carried by an item
	localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

	// Status codes returned with each result
	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_OVER  = 2'd2;

	// Sticky error flag bit positions
	localparam int FLAG_RANGE_BIT = 0;
	localparam int FLAG_OVER_BIT  = 1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [VIDX_W-1:0] vertex_a;
		logic [VIDX_W-1:0] vertex_b;
	} in_item_t;

	typedef struct packed {
		logic [FUNC_W-1:0] kind;
		logic [WORD_W-1:0] vertex_total;
		logic [WORD_W-1:0] rank_value;
		logic [STAT_W-1:0] status;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_item;
		logic idx_rst;
		logic idx_inc;
		logic idx_dec;
		logic idx_load_top;
		logic sweep_deg;
		logic sweep_tab;
		logic edge_rd_a;
		logic edge_wr_a;
		logic edge_wr_b;
		logic bin_issue;
		logic walk_issue;
		logic read_issue;
		logic clear_flags;
		logic respond;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic idx_end;
		logic idx_top;
		logic idx_one;
		logic pipe_empty;
		logic edge_ok;
		logic edge_same;
	} ctl_sts_t;

endpackage

`default_nettype wire

@@ design/graph_degree_rank_histogram.sv @@
// Top level of the graph degree rank histogram block: controller plus datapath.
// Depends on gdrh_pkg, gdrh_ctrl and gdrh_datapath.
//
// Every item accepted (start high while busy is low) yields exactly one result,
// shown for one cycle with done high in the first cycle that busy is low again;
// the receiver cannot stall it. Item latency is set by the sequencer and the
// single read and write port of each 1024-entry memory: an edge does one
// read-modify-write of the degree memory per endpoint (one for a self-loop,
// none when an endpoint is out of range), a clear zeroes one degree entry per
// cycle, and a finish for n vertices in use runs a sweep zeroing all 1024
// entries of the histogram and rank memories, bins one vertex per cycle,
// drains the binning pipeline, then walks one degree per cycle from n-1 down
// to 1. After reset the block holds busy high for a clearing pass over all
// three memories.
// The vertex_count register is written through cfg_valid/cfg_data at any time
// (cfg_ready is always high) but must only change while the block is idle.
`default_nettype none

module graph_degree_rank_histogram (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire gdrh_pkg::in_item_t          item,
	output logic                             done,
	output gdrh_pkg::out_item_t              result,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [gdrh_pkg::WORD_W-1:0] cfg_data
);

	gdrh_pkg::ctl_cmd_t cmd;
	gdrh_pkg::ctl_sts_t sts;

	// Register write is always taken
	assign cfg_ready = 1'b1;

	gdrh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	gdrh_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result),
		.done      (done)
	);

endmodule

`default_nettype wire

@@ design/gdrh_ctrl.sv @@
// Sequencing state machine for the graph degree rank histogram block.
// Depends on gdrh_pkg for the command and status structs and function codes.
`default_nettype none

module gdrh_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [gdrh_pkg::FUNC_W-1:0] func,
	input  wire gdrh_pkg::ctl_sts_t        sts,
	output gdrh_pkg::ctl_cmd_t             cmd,
	output logic                           busy
);

	typedef enum logic [12:0] {
		S_INIT    = 13'b0000000000001,
		S_IDLE    = 13'b0000000000010,
		S_EDGE_RA = 13'b0000000000100,
		S_EDGE_WA = 13'b0000000001000,
		S_EDGE_WB = 13'b0000000010000,
		S_FCLR    = 13'b0000000100000,
		S_FBIN    = 13'b0000001000000,
		S_FDRAIN  = 13'b0000010000000,
		S_FWALK   = 13'b0000100000000,
		S_WDRAIN  = 13'b0001000000000,
		S_READ    = 13'b0010000000000,
		S_CLR     = 13'b0100000000000,
		S_RESP    = 13'b1000000000000
	} state_t;

	state_t state_q, state_nx;

	// Hold the state; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Decode next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_INIT: begin
				cmd.sweep_deg = 1'b1;
				cmd.sweep_tab = 1'b1;
				cmd.idx_inc   = 1'b1;
				if (sts.idx_end) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_item = 1'b1;
					cmd.idx_rst   = 1'b1;
					case (func)
						gdrh_pkg::FUNC_EDGE:   state_nx = S_EDGE_RA;
						gdrh_pkg::FUNC_FINISH: state_nx = S_FCLR;
						gdrh_pkg::FUNC_READ:   state_nx = S_READ;
						default:               state_nx = S_CLR;
					endcase
				end
			end
			S_EDGE_RA: begin
				cmd.edge_rd_a = 1'b1;
				state_nx = sts.edge_ok ? S_EDGE_WA : S_RESP;
			end
			S_EDGE_WA: begin
				cmd.edge_wr_a = 1'b1;
				state_nx = sts.edge_same ? S_RESP : S_EDGE_WB;
			end
			S_EDGE_WB: begin
				cmd.edge_wr_b = 1'b1;
				state_nx = S_RESP;
			end
			S_FCLR: begin
				cmd.sweep_tab = 1'b1;
				cmd.idx_inc   = 1'b1;
				if (sts.idx_end) begin
					cmd.idx_inc = 1'b0;
					cmd.idx_rst = 1'b1;
					state_nx    = S_FBIN;
				end
			end
			S_FBIN: begin
				cmd.bin_issue = 1'b1;
				cmd.idx_inc   = 1'b1;
				if (sts.idx_top) begin
					state_nx = S_FDRAIN;
				end
			end
			S_FDRAIN: begin
				if (sts.pipe_empty) begin
					cmd.idx_load_top = 1'b1;
					state_nx = S_FWALK;
				end
			end
			S_FWALK: begin
				cmd.walk_issue = 1'b1;
				cmd.idx_dec    = 1'b1;
				if (sts.idx_one) begin
					state_nx = S_WDRAIN;
				end
			end
			S_WDRAIN: begin
				state_nx = S_RESP;
			end
			S_READ: begin
				cmd.read_issue = 1'b1;
				state_nx = S_RESP;
			end
			S_CLR: begin
				cmd.sweep_deg   = 1'b1;
				cmd.clear_flags = 1'b1;
				cmd.idx_inc     = 1'b1;
				if (sts.idx_end) begin
					state_nx = S_RESP;
				end
			end
			S_RESP: begin
				cmd.respond = 1'b1;
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_INIT;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/gdrh_datapath.sv @@
// Datapath of the graph degree rank histogram block: the degree, histogram
// and rank memories, the sweep index, the binning and walk pipelines, flags
// and the result register. Depends on gdrh_pkg.
`default_nettype none

module gdrh_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire gdrh_pkg::in_item_t          item,
	input  wire logic                        cfg_valid,
	input  wire logic [gdrh_pkg::WORD_W-1:0] cfg_data,
	input  wire gdrh_pkg::ctl_cmd_t          cmd,
	output gdrh_pkg::ctl_sts_t               sts,
	output gdrh_pkg::out_item_t              result,
	output logic                             done
);

	localparam int VW = gdrh_pkg::VIDX_W;
	localparam int WW = gdrh_pkg::WORD_W;
	localparam int DEPTH = gdrh_pkg::MAX_VERTICES;

	// Registers
	logic [WW-1:0]        vcnt_q;
	gdrh_pkg::in_item_t   item_q;
	logic [VW-1:0]        idx_q;
	logic [1:0]           flags_q;
	logic                 rd_ok_q;
	logic [WW-1:0]        run_q;
	gdrh_pkg::out_item_t  res_q;
	logic                 done_q;

	logic                 bv_s1;
	logic                 bv_s2;
	logic [VW-1:0]        baddr_s2;
	logic                 byp_s2;
	logic [WW-1:0]        bypd_s2;
	logic                 wv_s1;
	logic [VW-1:0]        waddr_s1;

	// Memories and their registered read data
	logic [WW-1:0] deg_mem  [0:DEPTH-1];
	logic [WW-1:0] hist_mem [0:DEPTH-1];
	logic [WW-1:0] rank_mem [0:DEPTH-1];
	logic [WW-1:0] deg_rd_q;
	logic [WW-1:0] hist_rd_q;
	logic [WW-1:0] rank_rd_q;

	// Combinational nets
	logic [WW-1:0] n_eff;
	logic [WW-1:0] n_top;
	logic [WW-1:0] a_ext;
	logic [WW-1:0] b_ext;
	logic          edge_ok;
	logic [WW:0]   deg_sum;
	logic [WW-1:0] deg_new;
	logic          d_ok;
	logic [WW-1:0] h_bin;
	logic [WW:0]   h_sum;
	logic [WW-1:0] h_inc;
	logic [WW:0]   run_sum;
	logic [WW-1:0] run_new;
	logic          walk_wr;

	logic [VW-1:0] deg_raddr;
	logic          deg_we;
	logic [VW-1:0] deg_waddr;
	logic [WW-1:0] deg_wdata;
	logic [VW-1:0] hist_raddr;
	logic          hist_we;
	logic [VW-1:0] hist_waddr;
	logic [WW-1:0] hist_wdata;
	logic          rank_we;
	logic [VW-1:0] rank_waddr;
	logic [WW-1:0] rank_wdata;
	logic [1:0]    flags_nx;

	// Clamp the vertex count to the supported range
	always_comb begin
		if (vcnt_q < gdrh_pkg::VCNT_MIN) begin
			n_eff = gdrh_pkg::VCNT_MIN;
		end else if (vcnt_q > gdrh_pkg::VCNT_MAX) begin
			n_eff = gdrh_pkg::VCNT_MAX;
		end else begin
			n_eff = vcnt_q;
		end
	end

	// Highest vertex and degree index in use
	assign n_top = n_eff - WW'(1);

	// Edge checks and the saturating degree update
	assign a_ext   = {1'b0, item_q.vertex_a};
	assign b_ext   = {1'b0, item_q.vertex_b};
	assign edge_ok = (a_ext < n_eff) && (b_ext < n_eff);
	assign deg_sum = {1'b0, deg_rd_q}
		+ ((cmd.edge_wr_a && (item_q.vertex_a == item_q.vertex_b))
			? (WW+1)'(2) : (WW+1)'(1));
	assign deg_new = deg_sum[WW] ? gdrh_pkg::WORD_MAX : deg_sum[WW-1:0];

	// Binning pipeline: degree in range, forwarded count, increment
	assign d_ok  = (deg_rd_q < n_eff);
	assign h_bin = byp_s2 ? bypd_s2 : hist_rd_q;
	assign h_sum = {1'b0, h_bin} + (WW+1)'(1);
	assign h_inc = h_sum[WW] ? gdrh_pkg::WORD_MAX : h_sum[WW-1:0];

	// Walk: running sum over nonzero counts
	assign run_sum = {1'b0, run_q} + {1'b0, hist_rd_q};
	assign run_new = run_sum[WW] ? gdrh_pkg::WORD_MAX : run_sum[WW-1:0];
	assign walk_wr = wv_s1 && (hist_rd_q != '0);

	// Degree memory port selection
	always_comb begin
		deg_raddr = item_q.vertex_a;
		if (cmd.bin_issue) begin
			deg_raddr = idx_q;
		end else if (cmd.edge_wr_a) begin
			deg_raddr = item_q.vertex_b;
		end
		deg_we    = cmd.sweep_deg || cmd.edge_wr_a || cmd.edge_wr_b;
		deg_waddr = item_q.vertex_a;
		deg_wdata = deg_new;
		if (cmd.sweep_deg) begin
			deg_waddr = idx_q;
			deg_wdata = '0;
		end else if (cmd.edge_wr_b) begin
			deg_waddr = item_q.vertex_b;
		end
	end

	// Histogram memory port selection
	always_comb begin
		hist_raddr = item_q.vertex_a;
		if (cmd.walk_issue) begin
			hist_raddr = idx_q;
		end else if (bv_s1) begin
			hist_raddr = deg_rd_q[VW-1:0];
		end
		hist_we    = cmd.sweep_tab || bv_s2;
		hist_waddr = baddr_s2;
		hist_wdata = h_inc;
		if (cmd.sweep_tab) begin
			hist_waddr = idx_q;
			hist_wdata = '0;
		end
	end

	// Rank memory write selection
	always_comb begin
		rank_we    = cmd.sweep_tab || walk_wr;
		rank_waddr = waddr_s1;
		rank_wdata = run_new;
		if (cmd.sweep_tab) begin
			rank_waddr = idx_q;
			rank_wdata = '0;
		end
	end

	// Memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		deg_rd_q <= deg_mem[deg_raddr];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		rank_rd_q <= rank_mem[item_q.vertex_a];
	end

	// Sticky flags: set on range and overflow events, drop on clear
	always_comb begin
		flags_nx = flags_q;
		if (cmd.clear_flags) begin
			flags_nx = '0;
		end else begin
			if ((cmd.edge_rd_a && !edge_ok) || (cmd.read_issue && !(a_ext < n_eff))) begin
				flags_nx[gdrh_pkg::FLAG_RANGE_BIT] = 1'b1;
			end
			if (((cmd.edge_wr_a || cmd.edge_wr_b) && (deg_new >= n_eff))
				|| (bv_s1 && !d_ok)) begin
				flags_nx[gdrh_pkg::FLAG_OVER_BIT] = 1'b1;
			end
		end
	end

	// Control registers: config, index, flags, pipeline valids, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q  <= gdrh_pkg::VCNT_RESET;
			idx_q   <= '0;
			flags_q <= '0;
			bv_s1   <= 1'b0;
			bv_s2   <= 1'b0;
			byp_s2  <= 1'b0;
			wv_s1   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				vcnt_q <= cfg_data;
			end
			if (cmd.idx_rst) begin
				idx_q <= '0;
			end else if (cmd.idx_load_top) begin
				idx_q <= n_top[VW-1:0];
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + VW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - VW'(1);
			end
			flags_q <= flags_nx;
			bv_s1   <= cmd.bin_issue;
			bv_s2   <= bv_s1 && d_ok;
			byp_s2  <= bv_s1 && d_ok && bv_s2 && (baddr_s2 == deg_rd_q[VW-1:0]);
			wv_s1   <= cmd.walk_issue;
			done_q  <= cmd.respond;
		end
	end

	// Payload registers: item, pipeline addresses, running sum, result
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		baddr_s2 <= deg_rd_q[VW-1:0];
		bypd_s2  <= h_inc;
		waddr_s1 <= idx_q;
		if (cmd.read_issue) begin
			rd_ok_q <= (a_ext < n_eff);
		end
		if (cmd.idx_load_top) begin
			run_q <= '0;
		end else if (walk_wr) begin
			run_q <= run_new;
		end
		if (cmd.respond) begin
			res_q.kind <= item_q.func;
			if ((item_q.func == gdrh_pkg::FUNC_READ) && rd_ok_q) begin
				res_q.vertex_total <= hist_rd_q;
				res_q.rank_value   <= rank_rd_q;
			end else begin
				res_q.vertex_total <= '0;
				res_q.rank_value   <= '0;
			end
			if (flags_q[gdrh_pkg::FLAG_RANGE_BIT]) begin
				res_q.status <= gdrh_pkg::STATUS_RANGE;
			end else if (flags_q[gdrh_pkg::FLAG_OVER_BIT]) begin
				res_q.status <= gdrh_pkg::STATUS_OVER;
			end else begin
				res_q.status <= gdrh_pkg::STATUS_OK;
			end
		end
	end

	// Status back to the controller
	assign sts.idx_end    = (idx_q == VW'(DEPTH - 1));
	assign sts.idx_top    = (idx_q == n_top[VW-1:0]);
	assign sts.idx_one    = (idx_q == VW'(1));
	assign sts.pipe_empty = !bv_s1 && !bv_s2;
	assign sts.edge_ok    = edge_ok;
	assign sts.edge_same  = (item_q.vertex_a == item_q.vertex_b);

	assign result = res_q;
	assign done   = done_q;

endmodule

`default_nettype wire

@@ design/gdrh_checker.sv @@
// Port-level checks for the graph degree rank histogram block, with the bind
// that attaches them to the top level. Depends on gdrh_pkg.
`default_nettype none

module gdrh_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire gdrh_pkg::in_item_t item,
	input wire logic               done,
	input wire gdrh_pkg::out_item_t result
);

	// An accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after an accepted beat");

	// Results never come in adjacent cycles
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// An accepted read returns a result of read kind, after the S_READ and S_RESP states
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.func == gdrh_pkg::FUNC_READ))
		|-> ##3 (done && (result.kind == gdrh_pkg::FUNC_READ)))
		else $error("read result missing or of wrong kind");

	// Only reads carry a count and rank
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.kind != gdrh_pkg::FUNC_READ))
		|-> ((result.vertex_total == '0) && (result.rank_value == '0)))
		else $error("nonzero count or rank on a non-read result");

	// Status is one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.status == gdrh_pkg::STATUS_OK)
			|| (result.status == gdrh_pkg::STATUS_RANGE)
			|| (result.status == gdrh_pkg::STATUS_OVER)))
		else $error("undefined status code");

endmodule

bind graph_degree_rank_histogram gdrh_checker u_gdrh_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

`default_nettype wire
